@@ sv/tepq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepq_pkg: shared types and constants of the timed event queue
// Opcodes, result status codes, the command word that travels from the
// front end to the execution core, and the stream field layout.
// ----------------------------------------------------------------------------
package tepq_pkg;

    // Default sizing, handed to the top level parameters
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // Command queue between front end and core
    localparam int CMD_Q_DEPTH = 2;

    // Field widths
    localparam int OP_W     = 2;
    localparam int EID_W    = 8;
    localparam int TIME_W   = 32;
    localparam int WAIT_W   = 14;
    localparam int CNT_O_W  = 5;
    localparam int STAT_W   = 2;

    // Slave tdata layout: event_id, delay_ms, now_ms, sleep (80 bits)
    localparam int S_TDATA_W = 80;
    localparam int EID_LSB   = 0;
    localparam int DELAY_LSB = 8;
    localparam int NOW_LSB   = 40;
    localparam int SLEEP_BIT = 72;

    // Master tdata layout: popped_id, wait_ms, removed_count, entries (32 bits)
    localparam int M_TDATA_W = 32;

    localparam logic [TIME_W-1:0] WAIT_CAP = 32'd10000;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_POPPED = 2'd1,
        ST_NONE   = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Per-cell action of the sorted store
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_INSERT,
        ACT_SHIFT,
        ACT_ROTATE
    } t_act;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SCAN,
        BS_REPORT
    } t_bstate;

    // tval carries the deadline for a push and the current time otherwise
    typedef struct packed {
        t_op                op;
        logic               sleep;
        logic [EID_W-1:0]   eid;
        logic [TIME_W-1:0]  tval;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic [EID_W-1:0]    pid;
        logic [WAIT_W-1:0]   wait_ms;
        logic [CNT_O_W-1:0]  removed;
        logic [CNT_O_W-1:0]  entries;
    } t_result;

endpackage

@@ sv/timed_event_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_priority_queue: deadline-sorted timer event queue
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid / tready    tuser: op; tdata: event_id, delay_ms,
//                                   now_ms, sleep
// m_axis    out  tvalid / tready    tuser: status; tdata: popped_id, wait_ms,
//                                   removed_count, entries
// Push, pop and unused opcodes are executed straight from the idle state of
// the core; a remove rotates the cell row once in the scan state, then reports.
// A result passes the input register, the command queue and the output
// register on its way out; sustained rate is one item per cycle apart from
// removes, while results are taken.
// Reset empties the store; no clearing pass is needed.
// A stalled result holds the core, while the command queue keeps taking input until it is full.
// ----------------------------------------------------------------------------
module timed_event_priority_queue #(
    parameter int QUEUE_DEPTH = tepq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = tepq_pkg::ID_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // event_id[7:0], delay_ms[39:8], now_ms[71:40], sleep[72], zero fill
    input  logic [tepq_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // op[1:0]
    input  logic [tepq_pkg::OP_W-1:0]       i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // popped_id[7:0], wait_ms[21:8], removed_count[26:22], entries[31:27]
    output logic [tepq_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // status[1:0]
    output logic [tepq_pkg::STAT_W-1:0]     o_m_axis_tuser
);
    import tepq_pkg::*;

    logic     w_f_valid;
    logic     w_f_ready;
    t_cmd     w_f_cmd;
    logic     w_q_valid;
    logic     w_q_ready;
    t_cmd     w_q_cmd;
    t_result  w_res;

    tepq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_s_data    (i_s_axis_tdata),
        .i_s_user    (i_s_axis_tuser),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready),
        .o_cmd       (w_f_cmd)
    );

    tepq_cmd_fifo u_cmd_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_f_valid),
        .o_wr_ready (w_f_ready),
        .i_wr_cmd   (w_f_cmd),
        .o_rd_valid (w_q_valid),
        .i_rd_ready (w_q_ready),
        .o_rd_cmd   (w_q_cmd)
    );

    tepq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (w_res)
    );

    assign o_m_axis_tuser = w_res.status;
    assign o_m_axis_tdata = {w_res.entries, w_res.removed, w_res.wait_ms, w_res.pid};

endmodule

@@ sv/tepq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepq_front: input stage of the timed event queue
// Takes input transactions, decodes the opcode and computes the deadline of
// a push, then hands one command word to the command queue.
// ----------------------------------------------------------------------------
module tepq_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_valid,
    output logic                             o_s_ready,
    input  logic [tepq_pkg::S_TDATA_W-1:0]   i_s_data,
    input  logic [tepq_pkg::OP_W-1:0]        i_s_user,
    output logic                             o_cmd_valid,
    input  logic                             i_cmd_ready,
    output tepq_pkg::t_cmd                   o_cmd
);
    import tepq_pkg::*;

    logic                r_valid;
    t_cmd                r_cmd;
    t_cmd                n_cmd;
    logic                w_accept;
    logic [TIME_W-1:0]   w_delay;
    logic [TIME_W-1:0]   w_now;

    assign o_s_ready   = !r_valid || i_cmd_ready;
    assign w_accept    = i_s_valid && o_s_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    assign w_delay = i_s_data[DELAY_LSB +: TIME_W];
    assign w_now   = i_s_data[NOW_LSB +: TIME_W];

    always_comb begin
        n_cmd.op    = t_op'(i_s_user);
        n_cmd.sleep = i_s_data[SLEEP_BIT];
        n_cmd.eid   = i_s_data[EID_LSB +: EID_W];
        // deadline wraps at 32 bits
        if (n_cmd.op == OP_PUSH) begin
            n_cmd.tval = w_now + w_delay;
        end else begin
            n_cmd.tval = w_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept || (r_valid && !i_cmd_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ sv/tepq_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepq_cmd_fifo: command queue of the timed event queue
// Short first-in first-out buffer that decouples the front end from the
// execution core.
// ----------------------------------------------------------------------------
module tepq_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  tepq_pkg::t_cmd  i_wr_cmd,
    output logic            o_rd_valid,
    input  logic            i_rd_ready,
    output tepq_pkg::t_cmd  o_rd_cmd
);
    import tepq_pkg::*;

    localparam int AW = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
    localparam int LW = $clog2(CMD_Q_DEPTH + 1);

    t_cmd            r_mem [CMD_Q_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [LW-1:0]   r_level;
    logic [LW-1:0]   n_level;
    logic            w_wr;
    logic            w_rd;

    assign o_wr_ready = r_level != LW'(CMD_Q_DEPTH);
    assign o_rd_valid = r_level != '0;
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    always_comb begin
        case ({w_wr, w_rd})
            2'b10:   n_level = r_level + LW'(1);
            2'b01:   n_level = r_level - LW'(1);
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_level <= n_level;
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(CMD_Q_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(CMD_Q_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

@@ sv/tepq_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tepq_back: execution core of the timed event queue
// Sorted store as a row of cells, earliest deadline in cell 0. A push inserts
// in place, a pop shifts the row, a remove rotates the row once,
// dropping matches. Results leave through an output register.
// ----------------------------------------------------------------------------
module tepq_back #(
    parameter int QUEUE_DEPTH = tepq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = tepq_pkg::ID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  tepq_pkg::t_cmd      i_cmd,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output tepq_pkg::t_result   o_res
);
    import tepq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [TIME_W-1:0]    r_dl [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   r_id [QUEUE_DEPTH];

    t_bstate              r_state;
    t_bstate              n_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [CW-1:0]        r_steps;
    logic [CW-1:0]        n_steps;
    logic [CW-1:0]        r_removed;
    logic [CW-1:0]        n_removed;
    logic [ID_BITS-1:0]   r_rm_id;
    logic [ID_BITS-1:0]   n_rm_id;

    logic                 r_res_valid;
    t_result              r_res;
    t_result              w_res;
    logic                 w_load;
    t_act                 w_act;

    logic [QUEUE_DEPTH-1:0] w_le;
    logic [QUEUE_DEPTH-1:0] w_top;

    logic [15:0]          w_eid16;
    logic [ID_BITS-1:0]   w_eid;
    logic [15:0]          w_pid16;
    logic [15:0]          w_rm16;
    logic [15:0]          w_cnt16;
    logic                 w_keep0;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_not_due;
    logic                 w_over;
    logic [TIME_W-1:0]    w_diff;
    logic                 w_out_free;
    logic                 w_take;

    assign w_eid16    = {8'd0, i_cmd.eid};
    assign w_eid      = w_eid16[ID_BITS-1:0];
    assign w_pid16    = 16'(r_id[0]);
    assign w_rm16     = 16'(r_removed);
    assign w_keep0    = r_id[0] != r_rm_id;
    assign w_full     = r_count == CW'(QUEUE_DEPTH);
    assign w_empty    = r_count == '0;
    assign w_not_due  = i_cmd.tval < r_dl[0];
    assign w_diff     = r_dl[0] - i_cmd.tval;
    assign w_over     = w_diff > WAIT_CAP;
    assign w_out_free = !r_res_valid || i_res_ready;
    assign o_cmd_ready = (r_state == BS_IDLE) && w_out_free;
    assign w_take     = i_cmd_valid && o_cmd_ready;
    assign o_res_valid = r_res_valid;
    assign o_res      = r_res;

    // Row of cells
    for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
        logic [TIME_W-1:0]  w_up_dl;
        logic [TIME_W-1:0]  w_dn_dl;
        logic [ID_BITS-1:0] w_up_id;
        logic [ID_BITS-1:0] w_dn_id;
        logic               w_below_le;
        logic [TIME_W-1:0]  n_dl;
        logic [ID_BITS-1:0] n_id;

        // cell holds a deadline not later than the new one
        assign w_le[j]  = (CW'(j) < r_count) && (r_dl[j] <= i_cmd.tval);
        assign w_top[j] = CW'(j + 1) == r_count;

        if (j == QUEUE_DEPTH - 1) begin : g_last
            assign w_up_dl = r_dl[j];
            assign w_up_id = r_id[j];
        end else begin : g_mid
            assign w_up_dl = r_dl[j + 1];
            assign w_up_id = r_id[j + 1];
        end

        if (j == 0) begin : g_first
            assign w_dn_dl    = r_dl[j];
            assign w_dn_id    = r_id[j];
            assign w_below_le = 1'b1;
        end else begin : g_rest
            assign w_dn_dl    = r_dl[j - 1];
            assign w_dn_id    = r_id[j - 1];
            assign w_below_le = w_le[j - 1];
        end

        always_comb begin
            n_dl = r_dl[j];
            n_id = r_id[j];
            case (w_act)
                ACT_INSERT: begin
                    if (!w_le[j]) begin
                        if (w_below_le) begin
                            n_dl = i_cmd.tval;
                            n_id = w_eid;
                        end else begin
                            n_dl = w_dn_dl;
                            n_id = w_dn_id;
                        end
                    end
                end
                ACT_SHIFT: begin
                    n_dl = w_up_dl;
                    n_id = w_up_id;
                end
                ACT_ROTATE: begin
                    // the head goes to the top of the row unless it matches
                    if (w_top[j] && w_keep0) begin
                        n_dl = r_dl[0];
                        n_id = r_id[0];
                    end else begin
                        n_dl = w_up_dl;
                        n_id = w_up_id;
                    end
                end
                default: begin
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            r_dl[j] <= n_dl;
            r_id[j] <= n_id;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_steps   = r_steps;
        n_removed = r_removed;
        n_rm_id   = r_rm_id;
        w_act     = ACT_HOLD;
        w_load    = 1'b0;
        w_res.status  = ST_DONE;
        w_res.pid     = '0;
        w_res.wait_ms = '0;
        w_res.removed = '0;
        case (r_state)
            BS_IDLE: begin
                if (w_take) begin
                    case (i_cmd.op)
                        OP_PUSH: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                w_res.status = ST_FULL;
                            end else begin
                                w_act   = ACT_INSERT;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_POP: begin
                            w_load = 1'b1;
                            w_res.status = ST_NONE;
                            if (!w_empty) begin
                                if (!w_not_due || (i_cmd.sleep && !w_over)) begin
                                    w_act        = ACT_SHIFT;
                                    n_count      = r_count - CW'(1);
                                    w_res.status = ST_POPPED;
                                    w_res.pid    = w_pid16[EID_W-1:0];
                                    if (w_not_due) begin
                                        w_res.wait_ms = w_diff[WAIT_W-1:0];
                                    end
                                end else if (i_cmd.sleep) begin
                                    w_res.wait_ms = WAIT_CAP[WAIT_W-1:0];
                                end
                            end
                        end
                        OP_REMOVE: begin
                            n_steps   = r_count;
                            n_removed = '0;
                            n_rm_id   = w_eid;
                            n_state   = w_empty ? BS_REPORT : BS_SCAN;
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            BS_SCAN: begin
                w_act   = ACT_ROTATE;
                n_steps = r_steps - CW'(1);
                if (!w_keep0) begin
                    n_count   = r_count - CW'(1);
                    n_removed = r_removed + CW'(1);
                end
                if (r_steps == CW'(1)) begin
                    n_state = BS_REPORT;
                end
            end
            BS_REPORT: begin
                if (w_out_free) begin
                    w_load        = 1'b1;
                    w_res.removed = w_rm16[CNT_O_W-1:0];
                    n_state       = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
        w_cnt16       = 16'(n_count);
        w_res.entries = w_cnt16[CNT_O_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_count     <= '0;
            r_steps     <= '0;
            r_removed   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_steps     <= n_steps;
            r_removed   <= n_removed;
            r_res_valid <= w_load || (r_res_valid && !i_res_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rm_id <= n_rm_id;
        if (w_load) begin
            r_res <= w_res;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_scan_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_SCAN) |-> (r_steps != '0))
        else $error("remove scan running with no steps left");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_res.status == ST_POPPED)) |=> (r_count + CW'(1) == $past(r_count)))
        else $error("popped event did not leave the store");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result loaded over a pending result");
`endif

endmodule
